>>> rtl/aeske_pkg.sv
package aeske_pkg;

    localparam int ROUND_COUNT = 10;
    localparam int KEY_WORDS   = 4;
    localparam int IDX_W       = 6;
    localparam int WORD_W      = 32;
    localparam int RCON_W      = 8;

    localparam logic [RCON_W-1:0] RCON_INIT = 8'h01;
    // x^8 + x^4 + x^3 + x + 1, top bit dropped
    localparam logic [RCON_W-1:0] GF_POLY   = 8'h1b;

    typedef struct packed {
        logic [63:0] key_high;
        logic [63:0] key_low;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]  word_index;
        logic [WORD_W-1:0] round_key_word;
        logic              last_word;
    } out_item_t;

    // controls for the shared word unit
    typedef struct packed {
        logic copy;   // key words: pass the oldest word through
        logic sub;    // first word of a round: rotate, substitute, add rcon
    } word_ctl_t;

    localparam logic [7:0] SBOX_TABLE [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
        8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
        8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
        8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
        8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
        8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
        8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
        8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
        8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
        8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
        8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
        8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
        8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
        8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
        8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [WORD_W-1:0] sub_word(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int b = 0; b < 4; b++) begin
            r[b*8 +: 8] = SBOX_TABLE[w[b*8 +: 8]];
        end
        return r;
    endfunction

    function automatic logic [RCON_W-1:0] gf_double(input logic [RCON_W-1:0] b);
        logic [RCON_W-1:0] r;
        r = {b[RCON_W-2:0], 1'b0};
        if (b[RCON_W-1]) begin
            r = r ^ GF_POLY;
        end
        return r;
    endfunction

endpackage

>>> rtl/aes128_key_expansion_core.sv
// AES-128 key schedule generator.
//
// Input channel (s_valid/s_ready/s_data): one 128-bit cipher key per
// transaction, key byte 0 in s_data.key_high[63:56].
// Result channel (m_valid/m_ready/m_data): 4*(ROUND_COUNT+1) = 44
// round-key words per key, in schedule order, each with its index and
// a last flag on the final word.
//
// Timing: one word is produced per cycle, unless m_ready stalls, through
// a single shared word unit (rotate, S-box, rcon XOR) fed by a four-word
// shift line. After a key is accepted the state register enters the run
// state, and the first word is then written to the output register.
// s_ready stays low until all 44 words have been generated.
// s_ready is high only while no schedule is in progress; the next key can
// be taken while the last word still sits in the output register.
//
// A stall on m_ready freezes the sequencer; the output register holds its
// word until taken. Reset returns to idle with the output register empty;
// nothing is kept between keys.
module aes128_key_expansion_core #(
    parameter int ROUND_COUNT = aeske_pkg::ROUND_COUNT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  aeske_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output aeske_pkg::out_item_t m_data
);

    localparam int WordCount = aeske_pkg::KEY_WORDS * (ROUND_COUNT + 1);
    localparam logic [aeske_pkg::IDX_W-1:0] LastIndex = aeske_pkg::IDX_W'(WordCount - 1);
    localparam logic [aeske_pkg::IDX_W-1:0] KeyWords  = aeske_pkg::IDX_W'(aeske_pkg::KEY_WORDS);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t                            state_reg, state_next;
    logic [aeske_pkg::IDX_W-1:0]       idx_reg, idx_next;
    logic [aeske_pkg::RCON_W-1:0]      rcon_reg;
    logic [aeske_pkg::WORD_W-1:0]      ring_reg [aeske_pkg::KEY_WORDS];
    logic                              m_valid_reg;
    aeske_pkg::out_item_t              out_reg;

    aeske_pkg::word_ctl_t              ctl;
    logic [aeske_pkg::WORD_W-1:0]      new_word;
    logic                              in_accept;
    logic                              gen;
    logic                              is_last;

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;
    assign gen       = (state_reg == ST_RUN) && (!m_valid_reg || m_ready);
    assign is_last   = (idx_reg == LastIndex);

    assign ctl.copy = (idx_reg < KeyWords);
    assign ctl.sub  = !ctl.copy && (idx_reg[1:0] == 2'b00);

    aeske_word_unit u_word (
        .ctl       (ctl),
        .back_word (ring_reg[0]),
        .prev_word (ring_reg[aeske_pkg::KEY_WORDS-1]),
        .rcon      (rcon_reg),
        .new_word  (new_word)
    );

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = ST_RUN;
                    idx_next   = '0;
                end
            end
            ST_RUN: begin
                if (gen) begin
                    idx_next = idx_reg + 1'b1;
                    if (is_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (gen) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath: key words rotate through the line, later words shift in
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            ring_reg[0] <= s_data.key_high[63:32];
            ring_reg[1] <= s_data.key_high[31:0];
            ring_reg[2] <= s_data.key_low[63:32];
            ring_reg[3] <= s_data.key_low[31:0];
            rcon_reg    <= aeske_pkg::RCON_INIT;
        end else if (gen) begin
            for (int k = 0; k < aeske_pkg::KEY_WORDS - 1; k++) begin
                ring_reg[k] <= ring_reg[k+1];
            end
            ring_reg[aeske_pkg::KEY_WORDS-1] <= new_word;
            if (ctl.sub) begin
                rcon_reg <= aeske_pkg::gf_double(rcon_reg);
            end
        end
        if (gen) begin
            out_reg.word_index     <= idx_reg;
            out_reg.round_key_word <= new_word;
            out_reg.last_word      <= is_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    a_start_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> (idx_reg == '0) && (rcon_reg == aeske_pkg::RCON_INIT))
        else $error("schedule did not restart at word zero");

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.last_word) |-> (m_data.word_index == LastIndex))
        else $error("last flag on wrong word");

    a_rcon_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (rcon_reg != '0))
        else $error("round constant collapsed to zero");

    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (gen && is_last) |=> s_ready && m_valid && m_data.last_word)
        else $error("sequencer did not stop after final word");

endmodule

>>> rtl/aeske_word_unit.sv
module aeske_word_unit (
    input  aeske_pkg::word_ctl_t                  ctl,
    input  logic [aeske_pkg::WORD_W-1:0]          back_word,
    input  logic [aeske_pkg::WORD_W-1:0]          prev_word,
    input  logic [aeske_pkg::RCON_W-1:0]          rcon,
    output logic [aeske_pkg::WORD_W-1:0]          new_word
);

    logic [aeske_pkg::WORD_W-1:0] rot_word;
    logic [aeske_pkg::WORD_W-1:0] t_word;

    assign rot_word = {prev_word[aeske_pkg::WORD_W-9:0], prev_word[aeske_pkg::WORD_W-1 -: 8]};

    always_comb begin
        if (ctl.sub) begin
            t_word = aeske_pkg::sub_word(rot_word)
                   ^ {rcon, {(aeske_pkg::WORD_W-aeske_pkg::RCON_W){1'b0}}};
        end else begin
            t_word = prev_word;
        end
        new_word = ctl.copy ? back_word : (back_word ^ t_word);
    end

endmodule

>>> tb/tb.sv
module tb;

    typedef aeske_pkg::in_item_t  in_item_t;
    typedef aeske_pkg::out_item_t out_item_t;

    localparam int KEY_WORDS   = aeske_pkg::KEY_WORDS;
    localparam int IDX_W       = aeske_pkg::IDX_W;
    localparam int SCHED_LEN   = KEY_WORDS * (aeske_pkg::ROUND_COUNT + 1);
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 2 * SCHED_LEN;
    localparam int RESET_CYCLES = 6;
    localparam int PHASES      = 4;

    localparam logic [7:0]  REDUCE_POLY = 8'h1b;
    localparam logic [7:0]  AFFINE_C    = 8'h63;
    localparam logic [7:0]  RCON_FIRST  = 8'h01;
    // FIPS-197 appendix A.1 key and its final schedule word
    localparam logic [127:0] FIPS_KEY   = 128'h2b7e151628aed2a6abf7158809cf4f3c;
    localparam logic [31:0]  FIPS_W43   = 32'hb6630ca6;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    aes128_key_expansion_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    in_item_t  key_q[$];
    out_item_t round_key_q[$];
    logic [7:0] sbox_lut [256];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int errors         = 0;
    int keys_sent      = 0;
    int words_checked  = 0;
    int idle_cycles    = 0;

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? REDUCE_POLY : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ a;
            a = xtime(a);
        end
        return p;
    endfunction

    // queue the 44 schedule words for one key
    function automatic void expand_key(input in_item_t key);
        logic [31:0] w [KEY_WORDS];
        logic [31:0] t;
        logic [7:0]  rc;
        out_item_t   item;
        w[0] = key.key_high[63:32];
        w[1] = key.key_high[31:0];
        w[2] = key.key_low[63:32];
        w[3] = key.key_low[31:0];
        rc = RCON_FIRST;
        for (int i = 0; i < SCHED_LEN; i++) begin
            if (i >= KEY_WORDS) begin
                t = w[(i - 1) % KEY_WORDS];
                if (i % KEY_WORDS == 0) begin
                    t = {t[23:0], t[31:24]};
                    t = {sbox_lut[t[31:24]], sbox_lut[t[23:16]],
                         sbox_lut[t[15:8]], sbox_lut[t[7:0]]} ^ {rc, 24'h0};
                    rc = xtime(rc);
                end
                w[i % KEY_WORDS] = w[i % KEY_WORDS] ^ t;
            end
            item.word_index     = i[IDX_W-1:0];
            item.round_key_word = w[i % KEY_WORDS];
            item.last_word      = (i == SCHED_LEN - 1);
            round_key_q.push_back(item);
        end
    endfunction

    task automatic wait_drained();
        while (key_q.size() != 0 || s_valid || round_key_q.size() != 0)
            @(negedge aclk);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else begin
            if (s_valid && s_ready) begin
                expand_key(s_data);
                keys_sent++;
            end
            if (!s_valid || s_ready) begin
                if (key_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_data  <= key_q.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin : monitor
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (round_key_q.size() == 0) begin
                    $display("%0t: unexpected transaction idx=%0d word=%h last=%b",
                             $time, m_data.word_index, m_data.round_key_word,
                             m_data.last_word);
                    errors++;
                end else begin
                    want = round_key_q.pop_front();
                    words_checked++;
                    if (m_data.word_index !== want.word_index ||
                        m_data.round_key_word !== want.round_key_word ||
                        m_data.last_word !== want.last_word) begin
                        $display("%0t: mismatch exp idx=%0d word=%h last=%b, %s",
                                 $time, want.word_index, want.round_key_word,
                                 want.last_word,
                                 $sformatf("got idx=%0d word=%h last=%b",
                                           m_data.word_index,
                                           m_data.round_key_word,
                                           m_data.last_word));
                        errors++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog: cycles with no transaction on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] inv;
        in_item_t   key;
        int         count;

        // S-box built independently: GF(2^8) inverse, then the affine map
        for (int x = 0; x < 256; x++) begin
            inv = 8'h00;
            for (int y = 1; y < 256; y++)
                if (gmul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
            sbox_lut[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                        ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ AFFINE_C;
        end

        // sanity check of the predictor against the published vector
        expand_key(in_item_t'(FIPS_KEY));
        if (round_key_q[SCHED_LEN-1].round_key_word !== FIPS_W43) begin
            $display("%0t: predictor mismatch exp word=%h got word=%h", $time,
                     FIPS_W43, round_key_q[SCHED_LEN-1].round_key_word);
            errors++;
        end
        round_key_q.delete();

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed keys, back to back
        key_q.push_back(in_item_t'({64'h0, 64'h0}));
        key_q.push_back(in_item_t'({64'h0, 64'h0}));
        key_q.push_back(in_item_t'({64'hffffffffffffffff, 64'hffffffffffffffff}));
        key_q.push_back(in_item_t'(FIPS_KEY));
        key_q.push_back(in_item_t'({64'h0001020304050607, 64'h08090a0b0c0d0e0f}));
        key_q.push_back(in_item_t'({64'h5555555555555555, 64'haaaaaaaaaaaaaaaa}));
        key_q.push_back(in_item_t'({64'haaaaaaaaaaaaaaaa, 64'h5555555555555555}));
        key_q.push_back(in_item_t'({64'hffffffffffffffff, 64'h0}));
        key_q.push_back(in_item_t'({64'h0, 64'hffffffffffffffff}));
        key_q.push_back(in_item_t'({64'h8000000000000000, 64'h0}));
        key_q.push_back(in_item_t'({64'h0, 64'h0000000000000001}));
        key_q.push_back(in_item_t'({64'h0, 64'h00000000ffffffff}));
        // sender holds off here until the directed schedules are all out
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            count = (p < 2) ? 53 : 52;
            repeat (count) begin
                case ($urandom_range(5))
                    0: begin
                        key = '0;
                        repeat ($urandom_range(1, 3)) key[$urandom_range(127)] = 1'b1;
                    end
                    1: begin
                        key = '1;
                        repeat ($urandom_range(1, 3)) key[$urandom_range(127)] = 1'b0;
                    end
                    default: key = {$urandom, $urandom, $urandom, $urandom};
                endcase
                key_q.push_back(key);
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (round_key_q.size() != 0) begin
            $display("%0t: %0d round-key words never arrived", $time, round_key_q.size());
            errors++;
        end
        $display("tb: %0d keys expanded, %0d round-key words checked, %0d errors",
                 keys_sent, words_checked, errors);
        $display("tb: directed edge keys plus random keys under sender gaps and receiver stalls");
        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
